// ===== hdl/ale_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types and constants of the ordered list engine: operation and
// status codes, controller states, datapath command and status bundles.
// ----------------------------------------------------------------------------
package ale_pkg;

   localparam int DATA_W    = 32;
   localparam int CNT_W     = 5;
   localparam int MODE_W    = 4;
   localparam int DEPTH_DEF = 16;
   localparam int CAP_RESET = 16;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;
   localparam int REQ_DW    = 72;
   localparam int RSP_DW    = 16;

   localparam logic [CSR_AW-1:0] ADDR_CAPACITY = 3'd0;

   typedef enum logic [MODE_W-1:0] {
      MD_INS_FRONT = 4'd0,
      MD_INS_BACK  = 4'd1,
      MD_RM_FRONT  = 4'd2,
      MD_RM_BACK   = 4'd3,
      MD_RM_AT     = 4'd4,
      MD_FIND      = 4'd5,
      MD_REPLACE   = 4'd6,
      MD_RM_VALUE  = 4'd7,
      MD_CLEAR     = 4'd8
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_BAD_POS   = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_DECODE,
      OP_RD_BELOW,
      OP_RD_ABOVE,
      OP_RD_AT,
      OP_WR_UP,
      OP_WR_DN,
      OP_CHECK,
      OP_FINISH
   } dp_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_UP_RD,
      S_UP_WR,
      S_DN_RD,
      S_DN_WR,
      S_SC_RD,
      S_SC_CHK,
      S_DONE
   } state_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      mode_type         mode;
      logic             err_hit;
      logic             ptr_zero;
      logic             dn_end;
      logic             sc_end;
      logic             match;
      logic             pend_valid;
      logic             out_free;
      logic [CNT_W-1:0] cnt;
   } dp_sts_type;

endpackage

// ===== hdl/ale_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_ctrl
// Sequencer of the list engine: walks each operation through decode,
// shift, scan and finish steps and issues at most one command per cycle.
// ----------------------------------------------------------------------------
module ale_ctrl
   import ale_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (sts.err_hit) begin
               state_in = S_DONE;
            end else begin
               unique case (sts.mode)
                  MD_INS_FRONT:                     state_in = S_UP_RD;
                  MD_RM_FRONT, MD_RM_AT:            state_in = S_DN_RD;
                  MD_FIND, MD_REPLACE, MD_RM_VALUE: state_in = S_SC_RD;
                  MD_INS_BACK, MD_RM_BACK, MD_CLEAR: state_in = S_DONE;
                  default:                          state_in = S_IDLE;
               endcase
            end
         end
         S_UP_RD: begin
            state_in = sts.ptr_zero ? S_DONE : S_UP_WR;
         end
         S_UP_WR: begin
            state_in = S_UP_RD;
         end
         S_DN_RD: begin
            state_in = sts.dn_end ? S_DONE : S_DN_WR;
         end
         S_DN_WR: begin
            state_in = S_DN_RD;
         end
         S_SC_RD: begin
            state_in = sts.sc_end ? S_DONE : S_SC_CHK;
         end
         S_SC_CHK: begin
            priority if (sts.match && sts.mode == MD_RM_VALUE) begin
               state_in = S_DN_RD;
            end else if (sts.match && sts.pend_valid && !sts.out_free) begin
               state_in = S_SC_CHK;
            end else begin
               state_in = S_SC_RD;
            end
         end
         S_DONE: begin
            if (sts.out_free) state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      cmd.op     = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = OP_LOAD;
         end
         S_DECODE: begin
            cmd.op = OP_DECODE;
         end
         S_UP_RD: begin
            if (!sts.ptr_zero) cmd.op = OP_RD_BELOW;
         end
         S_UP_WR: begin
            cmd.op = OP_WR_UP;
         end
         S_DN_RD: begin
            if (!sts.dn_end) cmd.op = OP_RD_ABOVE;
         end
         S_DN_WR: begin
            cmd.op = OP_WR_DN;
         end
         S_SC_RD: begin
            if (!sts.sc_end) cmd.op = OP_RD_AT;
         end
         S_SC_CHK: begin
            // hold while an earlier match still needs the output slot
            if (!(sts.match && sts.mode != MD_RM_VALUE && sts.pend_valid
                  && !sts.out_free)) begin
               cmd.op = OP_CHECK;
            end
         end
         S_DONE: begin
            if (sts.out_free) cmd.op = OP_FINISH;
         end
      endcase
   end

endmodule

// ===== hdl/ale_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_dpath
// Datapath of the list engine: entry store with one write and one
// registered read port, count, walk pointer, pending match and the
// result register.
// ----------------------------------------------------------------------------
module ale_dpath
   import ale_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_sts_type        sts,
   input  logic [CNT_W-1:0]  capacity,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [DATA_W-1:0] req_value,
   input  logic [DATA_W-1:0] req_new_value,
   input  logic [CNT_W-1:0]  req_position,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output status_type        rsp_status,
   output logic [CNT_W-1:0]  rsp_match_position,
   output logic [CNT_W-1:0]  rsp_entry_count,
   output logic              rsp_last
);

   localparam int IDX_W = $clog2(DEPTH);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   mode_type          mode_ff, mode_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [DATA_W-1:0] nval_ff, nval_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  pend_ff, pend_in;
   status_type        err_ff, err_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]  cap_eff;
   status_type        err_c;
   logic [CNT_W:0]    ptr_p1;
   logic              match;
   logic              out_free;

   logic              mem_we;
   logic [IDX_W-1:0]  mem_wa;
   logic [DATA_W-1:0] mem_wd;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;

   logic              emit;
   status_type        em_status;
   logic [CNT_W-1:0]  em_pos;
   logic              em_last;

   assign cap_eff  = (32'(capacity) > DEPTH) ? CNT_W'(DEPTH) : capacity;
   assign ptr_p1   = {1'b0, ptr_ff} + 1'b1;
   assign match    = (rdata_ff == val_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      err_c = ST_OK;
      unique case (mode_ff)
         MD_INS_FRONT, MD_INS_BACK: begin
            if (count_ff >= cap_eff) err_c = ST_FULL;
         end
         MD_RM_FRONT, MD_RM_BACK, MD_FIND: begin
            if (count_ff == '0) err_c = ST_EMPTY;
         end
         MD_RM_AT: begin
            priority if (count_ff == '0) begin
               err_c = ST_EMPTY;
            end else if (pos_ff == '0 || pos_ff > count_ff) begin
               err_c = ST_BAD_POS;
            end
         end
         default: err_c = ST_OK;
      endcase
   end

   always_comb begin
      sts.mode       = mode_ff;
      sts.err_hit    = (err_c != ST_OK);
      sts.ptr_zero   = (ptr_ff == '0);
      sts.dn_end     = (ptr_p1 >= {1'b0, count_ff});
      sts.sc_end     = (ptr_ff >= count_ff);
      sts.match      = match;
      sts.pend_valid = (pend_ff != '0);
      sts.out_free   = out_free;
      sts.cnt        = count_ff;
   end

   always_comb begin
      mode_in   = mode_ff;
      val_in    = val_ff;
      nval_in   = nval_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      pend_in   = pend_ff;
      err_in    = err_ff;
      mem_we    = 1'b0;
      mem_wa    = IDX_W'(ptr_ff);
      mem_wd    = rdata_ff;
      rd_en     = 1'b0;
      rd_addr   = IDX_W'(ptr_ff);
      emit      = 1'b0;
      em_status = ST_OK;
      em_pos    = '0;
      em_last   = 1'b1;

      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            mode_in = mode_type'(req_mode);
            val_in  = req_value;
            nval_in = req_new_value;
            pos_in  = req_position;
            pend_in = '0;
         end
         OP_DECODE: begin
            err_in = err_c;
            unique case (mode_ff)
               MD_INS_FRONT: ptr_in = count_ff;
               MD_RM_AT:     ptr_in = pos_ff - 1'b1;
               default:      ptr_in = '0;
            endcase
         end
         OP_RD_BELOW: begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(ptr_ff - 1'b1);
         end
         OP_RD_ABOVE: begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(ptr_p1[CNT_W-1:0]);
         end
         OP_RD_AT: begin
            rd_en = 1'b1;
         end
         OP_WR_UP: begin
            mem_we = 1'b1;
            ptr_in = ptr_ff - 1'b1;
         end
         OP_WR_DN: begin
            mem_we = 1'b1;
            ptr_in = ptr_p1[CNT_W-1:0];
         end
         OP_CHECK: begin
            if (match && mode_ff == MD_RM_VALUE) begin
               // keep ptr: the shift down starts at the matching entry
               pend_in = ptr_p1[CNT_W-1:0];
            end else if (match) begin
               if (mode_ff == MD_REPLACE) begin
                  mem_we = 1'b1;
                  mem_wd = nval_ff;
               end
               // release the previous match, it is not the final one
               if (pend_ff != '0) begin
                  emit    = 1'b1;
                  em_pos  = pend_ff;
                  em_last = 1'b0;
               end
               pend_in = ptr_p1[CNT_W-1:0];
               ptr_in  = ptr_p1[CNT_W-1:0];
            end else begin
               ptr_in = ptr_p1[CNT_W-1:0];
            end
         end
         OP_FINISH: begin
            emit = 1'b1;
            if (err_ff != ST_OK) begin
               em_status = err_ff;
            end else begin
               unique case (mode_ff)
                  MD_INS_FRONT: begin
                     mem_we   = 1'b1;
                     mem_wa   = '0;
                     mem_wd   = val_ff;
                     count_in = count_ff + 1'b1;
                  end
                  MD_INS_BACK: begin
                     mem_we   = 1'b1;
                     mem_wa   = IDX_W'(count_ff);
                     mem_wd   = val_ff;
                     count_in = count_ff + 1'b1;
                  end
                  MD_RM_FRONT, MD_RM_BACK, MD_RM_AT: begin
                     count_in = count_ff - 1'b1;
                  end
                  MD_FIND, MD_REPLACE: begin
                     if (pend_ff != '0) begin
                        em_pos = pend_ff;
                     end else begin
                        em_status = ST_NOT_FOUND;
                     end
                  end
                  MD_RM_VALUE: begin
                     if (pend_ff != '0) begin
                        em_pos   = pend_ff;
                        count_in = count_ff - 1'b1;
                     end else begin
                        em_status = ST_NOT_FOUND;
                     end
                  end
                  MD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     emit = 1'b0;
                  end
               endcase
            end
         end
         default: begin
         end
      endcase

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = em_status;
         rsp_pos_in    = em_pos;
         rsp_cnt_in    = count_in;
         rsp_last_in   = em_last;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      val_ff        <= val_in;
      nval_ff       <= nval_in;
      pos_ff        <= pos_in;
      ptr_ff        <= ptr_in;
      pend_ff       <= pend_in;
      err_ff        <= err_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_match_position = rsp_pos_ff;
   assign rsp_entry_count    = rsp_cnt_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

// ===== hdl/array_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_engine
// Ordered list of signed 32-bit values with insert, remove, find, replace
// and clear operations; each operation answers with status and count.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req_      in         tvalid/tready          tuser mode, tdata value/new_value/position
//  rsp_      out        tvalid/tready/tlast    tdata status/match_position/entry_count
//  csr_      in         psel/penable, pready=1 capacity at byte address 0
//
//  One operation is in flight at a time; the next item is taken once the
//  sequencer is back in idle, even while the last result still waits.
//  Insert back, remove back, clear and errors only decode and finish;
//  insert front shifts all entries up, positional removals those above
//  the position down, find, replace and remove-value scan: one read and
//  one write or check per entry via the store's single registered read port.
//  A stalled result channel holds the scan at its next match.
//  Reset is synchronous; it clears count and control, not the store.
// ----------------------------------------------------------------------------
module array_list_engine
   import ale_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // [31:0] value, [63:32] new_value, [68:64] position, rest zero
   input  logic [REQ_DW-1:0] req_tdata,
   // [3:0] mode
   input  logic [MODE_W-1:0] req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // [2:0] status, [7:3] match_position, [12:8] entry_count, rest zero
   output logic [RSP_DW-1:0] rsp_tdata,
   output logic              rsp_tlast,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   dp_cmd_type       cmd;
   dp_sts_type       sts;
   logic [CNT_W-1:0] cap_ff;
   status_type       rsp_status;
   logic [CNT_W-1:0] rsp_pos;
   logic [CNT_W-1:0] rsp_cnt;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CNT_W'(CAP_RESET);
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr == ADDR_CAPACITY) begin
         cap_ff <= csr_pwdata[CNT_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr == ADDR_CAPACITY) ? CSR_DW'(cap_ff) : '0;

   ale_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   ale_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .capacity           (cap_ff),
      .req_mode           (req_tuser),
      .req_value          (req_tdata[DATA_W-1:0]),
      .req_new_value      (req_tdata[2*DATA_W-1:DATA_W]),
      .req_position       (req_tdata[2*DATA_W+CNT_W-1:2*DATA_W]),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .rsp_status         (rsp_status),
      .rsp_match_position (rsp_pos),
      .rsp_entry_count    (rsp_cnt),
      .rsp_last           (rsp_tlast)
   );

   assign rsp_tdata = RSP_DW'({rsp_cnt, rsp_pos, rsp_status});

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      sts.cnt <= DEPTH)
      else $error("entry count beyond store depth");

   a_mid_status_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[2:0] == ST_OK)
      else $error("non-final result without ok status");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while an operation is in flight");
`endif

endmodule
